// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the port checker in ypr_checker.sv
// each macro clocks on clk; the first one is also disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
// checked at every edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== hw/rtl/ypr_pkg.sv =====
// shared types, coefficients and register codes for the yuv pair to rgb converter
// no dependencies
package ypr_pkg;

  localparam int FRAC_BITS = 13;
  localparam int PIX_W     = 8;
  localparam int OFS_W     = 23;
  localparam int LANES     = 2;
  localparam int CHANS     = 3;
  localparam int IN_W      = 4 * PIX_W;
  localparam int OUT_W     = LANES * CHANS * PIX_W;
  localparam int CFG_IDX_W = 3;

  // fixed point widths
  localparam int COEF_W = FRAC_BITS + 2;
  localparam int MUL_W  = FRAC_BITS + 10;
  localparam int SUM_W  = (FRAC_BITS + 13 > OFS_W + 3) ? FRAC_BITS + 13 : OFS_W + 3;
  localparam int T_W    = SUM_W - FRAC_BITS;

  // coefficients rounded to nearest from thousandths
  localparam logic [COEF_W-1:0] C_Y_FULL     = COEF_W'((1164 * (1 << FRAC_BITS) + 500) / 1000);
  localparam logic [COEF_W-1:0] C_RV_FULL    = COEF_W'((1596 * (1 << FRAC_BITS) + 500) / 1000);
  localparam logic [COEF_W-1:0] C_GV_FULL    = COEF_W'((813 * (1 << FRAC_BITS) + 500) / 1000);
  localparam logic [COEF_W-1:0] C_GU_FULL    = COEF_W'((392 * (1 << FRAC_BITS) + 500) / 1000);
  localparam logic [COEF_W-1:0] C_BU_FULL    = COEF_W'((2017 * (1 << FRAC_BITS) + 500) / 1000);
  localparam logic [COEF_W-1:0] C_RV_STUDIO  = COEF_W'((1371 * (1 << FRAC_BITS) + 500) / 1000);
  localparam logic [COEF_W-1:0] C_GV_STUDIO  = COEF_W'((698 * (1 << FRAC_BITS) + 500) / 1000);
  localparam logic [COEF_W-1:0] C_GU_STUDIO  = COEF_W'((336 * (1 << FRAC_BITS) + 500) / 1000);
  localparam logic [COEF_W-1:0] C_BU_STUDIO  = COEF_W'((1732 * (1 << FRAC_BITS) + 500) / 1000);

  localparam logic [PIX_W-1:0] LUMA_BLACK = PIX_W'(16);
  localparam int RANGE_LO   = 16;
  localparam int RANGE_SPAN = 235 - 16 + 1;
  localparam int PIX_MAX    = 255;

  // floor(d * 255 / 220) as (d * SCALE_K) >> SCALE_SHIFT, exact for d below 220
  localparam int SCALE_SHIFT = 24;
  localparam int SCALE_RECIP = ((1 << SCALE_SHIFT) + RANGE_SPAN - 1) / RANGE_SPAN;
  localparam int SCALE_K     = PIX_MAX * SCALE_RECIP;
  localparam int SCALE_K_W   = 25;
  localparam int PROD_W      = PIX_W + SCALE_K_W;

  localparam logic [OFS_W-1:0] RED_OFS_RST   = -OFS_W'(1673527);
  localparam logic [OFS_W-1:0] GREEN_OFS_RST = OFS_W'(1263534);
  localparam logic [OFS_W-1:0] BLUE_OFS_RST  = -OFS_W'(2114978);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STUDIO_MODE,
    REG_CHROMA_U_FIRST,
    REG_RED_OFS,
    REG_GREEN_OFS,
    REG_BLUE_OFS
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_MAX,
    KIND_PASS,
    KIND_SCALED
  } chan_kind_t;

  typedef struct packed {
    chan_kind_t        kind;
    logic [PIX_W-1:0]  val;
    logic [PROD_W-1:0] prod;
  } chan_res_t;

  typedef struct packed {
    chan_res_t red;
    chan_res_t green;
    chan_res_t blue;
  } lane_res_t;

  typedef struct packed {
    logic p1;
    logic p2;
    logic p3;
    logic p4;
  } lane_en_t;

  typedef struct packed {
    logic             studio;
    logic [OFS_W-1:0] red_ofs;
    logic [OFS_W-1:0] green_ofs;
    logic [OFS_W-1:0] blue_ofs;
  } cfg_t;

endpackage

// ===== hw/rtl/ypr_lane.sv =====
// one pixel lane: constant products, channel sums, truncation and range classification
// depends on ypr_pkg
module ypr_lane import ypr_pkg::*; (
  input  logic             clk,
  input  lane_en_t         en,
  input  cfg_t             cfg,
  input  logic [PIX_W-1:0] luma,
  input  logic [PIX_W-1:0] u,
  input  logic [PIX_W-1:0] v,
  output lane_res_t        res
);

  localparam int TRUNC_BIAS = (1 << FRAC_BITS) - 1;

  logic [PIX_W-1:0]  luma_ofs;
  logic [COEF_W-1:0] k_rv, k_gv, k_gu, k_bu;
  logic [MUL_W-1:0]  y_term, rv, gv, gu, bu;
  logic [SUM_W-1:0]  y_ext, rv_ext, gv_ext, gu_ext, bu_ext;
  logic [SUM_W-1:0]  ofs_r, ofs_g, ofs_b;
  logic [SUM_W-1:0]  r_sum, g_sum, b_sum;
  logic [T_W-1:0]    r_t, g_t, b_t;

  function automatic logic [T_W-1:0] trunc_zero(logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] biased;
    biased = s + (s[SUM_W-1] ? SUM_W'(TRUNC_BIAS) : '0);
    return biased[SUM_W-1:FRAC_BITS];
  endfunction

  function automatic chan_res_t classify(logic [T_W-1:0] t, logic studio);
    chan_res_t        c;
    logic [T_W-1:0]   d;
    d      = t - T_W'(RANGE_LO);
    c.kind = KIND_ZERO;
    c.val  = '0;
    c.prod = PROD_W'(d[PIX_W-1:0]) * PROD_W'(SCALE_K);
    if (studio) begin
      if (d[T_W-1]) begin
        c.kind = KIND_ZERO;
      end else if (d >= T_W'(RANGE_SPAN)) begin
        c.kind = KIND_MAX;
      end else begin
        c.kind = KIND_SCALED;
      end
    end else begin
      if (t[T_W-1]) begin
        c.kind = KIND_ZERO;
      end else if (t > T_W'(PIX_MAX)) begin
        c.kind = KIND_MAX;
      end else begin
        c.kind = KIND_PASS;
        c.val  = t[PIX_W-1:0];
      end
    end
    return c;
  endfunction

  always_comb begin
    luma_ofs = (luma > LUMA_BLACK) ? luma - LUMA_BLACK : '0;
    k_rv     = cfg.studio ? C_RV_STUDIO : C_RV_FULL;
    k_gv     = cfg.studio ? C_GV_STUDIO : C_GV_FULL;
    k_gu     = cfg.studio ? C_GU_STUDIO : C_GU_FULL;
    k_bu     = cfg.studio ? C_BU_STUDIO : C_BU_FULL;
  end

  // stage 1: constant products
  always_ff @(posedge clk) begin
    if (en.p1) begin
      if (cfg.studio) begin
        y_term <= MUL_W'({luma, FRAC_BITS'(0)});
      end else begin
        y_term <= MUL_W'(C_Y_FULL) * MUL_W'(luma_ofs);
      end
      rv <= MUL_W'(k_rv) * MUL_W'(v);
      gv <= MUL_W'(k_gv) * MUL_W'(v);
      gu <= MUL_W'(k_gu) * MUL_W'(u);
      bu <= MUL_W'(k_bu) * MUL_W'(u);
    end
  end

  always_comb begin
    y_ext  = SUM_W'(y_term);
    rv_ext = SUM_W'(rv);
    gv_ext = SUM_W'(gv);
    gu_ext = SUM_W'(gu);
    bu_ext = SUM_W'(bu);
    ofs_r  = {{(SUM_W - OFS_W){cfg.red_ofs[OFS_W-1]}}, cfg.red_ofs};
    ofs_g  = {{(SUM_W - OFS_W){cfg.green_ofs[OFS_W-1]}}, cfg.green_ofs};
    ofs_b  = {{(SUM_W - OFS_W){cfg.blue_ofs[OFS_W-1]}}, cfg.blue_ofs};
  end

  // stage 2: channel sums, two's complement
  always_ff @(posedge clk) begin
    if (en.p2) begin
      r_sum <= y_ext + rv_ext + ofs_r;
      g_sum <= y_ext - gv_ext - gu_ext + ofs_g;
      b_sum <= y_ext + bu_ext + ofs_b;
    end
  end

  // stage 3: drop fraction toward zero
  always_ff @(posedge clk) begin
    if (en.p3) begin
      r_t <= trunc_zero(r_sum);
      g_t <= trunc_zero(g_sum);
      b_t <= trunc_zero(b_sum);
    end
  end

  // stage 4: clamp decision and studio rescale product
  always_ff @(posedge clk) begin
    if (en.p4) begin
      res.red   <= classify(r_t, cfg.studio);
      res.green <= classify(g_t, cfg.studio);
      res.blue  <= classify(b_t, cfg.studio);
    end
  end

endmodule

// ===== hw/rtl/ypr_merge.sv =====
// merge stage: finishes each lane's channels and holds the output transfer register
// depends on ypr_pkg
module ypr_merge import ypr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  lane_res_t        lane_res [LANES],
  output logic             ready,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata
);

  logic [OUT_W-1:0] data_next;

  function automatic logic [PIX_W-1:0] finish(chan_res_t c);
    logic [PIX_W-1:0] r;
    unique case (c.kind)
      KIND_ZERO:   r = '0;
      KIND_MAX:    r = PIX_W'(PIX_MAX);
      KIND_PASS:   r = c.val;
      KIND_SCALED: r = c.prod[SCALE_SHIFT +: PIX_W];
      default:     r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    data_next = '0;
    for (int l = 0; l < LANES; l++) begin
      data_next[(CHANS * l) * PIX_W +: PIX_W]     = finish(lane_res[l].red);
      data_next[(CHANS * l + 1) * PIX_W +: PIX_W] = finish(lane_res[l].green);
      data_next[(CHANS * l + 2) * PIX_W +: PIX_W] = finish(lane_res[l].blue);
    end
  end

  assign ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      m_axis_tdata <= data_next;
    end
  end

endmodule

// ===== hw/rtl/yuv_pair_to_rgb.sv =====
// yuv_pair_to_rgb: converts one YCbCr pixel pair per transfer into two RGB pixels.
// Input stream s_axis: one transfer carries two luma bytes and a shared chroma pair.
// Output stream m_axis: one transfer per input transfer, same order, six bytes.
// Configuration: write port cfg_wr_en / cfg_index / cfg_data, written while idle:
//   0 studio range mode, 1 chroma U first, 2..4 red/green/blue offsets (Q13 signed).
// Two identical pixel lanes run side by side, each a four stage pipeline
// (products, sums, truncation, clamp/rescale product); a merge stage finishes the
// channels and holds the output register.
// Input passes four lane stages, then the merge register; throughput is one pixel pair
// per cycle while the receiver keeps up, every multiply by a constant and registered.
// Each stage advances when it is empty or the next one advances, so a stalled
// receiver only blocks input once all five stages are full; bubbles are squeezed out.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults:
// full range, U first, offsets -1.596*128, 1.205*128, -2.017*128 in Q13.
// Depends on ypr_pkg, ypr_lane and ypr_merge.
module yuv_pair_to_rgb import ypr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // luma_first, luma_second, chroma_first, chroma_second
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // red_left, green_left, blue_left, red_right, green_right, blue_right
  output logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OFS_W-1:0]     cfg_data
);

  cfg_t             cfg;
  logic             chroma_u_first;
  logic [3:0]       stage_valid;
  logic             rdy1, rdy2, rdy3, rdy4;
  logic             merge_ready;
  lane_en_t         en;
  logic [PIX_W-1:0] luma [LANES];
  logic [PIX_W-1:0] chroma_u, chroma_v;
  lane_res_t        lane_res [LANES];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.studio     <= 1'b0;
      chroma_u_first <= 1'b1;
      cfg.red_ofs    <= RED_OFS_RST;
      cfg.green_ofs  <= GREEN_OFS_RST;
      cfg.blue_ofs   <= BLUE_OFS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STUDIO_MODE:    cfg.studio     <= cfg_data[0];
        REG_CHROMA_U_FIRST: chroma_u_first <= cfg_data[0];
        REG_RED_OFS:        cfg.red_ofs    <= cfg_data;
        REG_GREEN_OFS:      cfg.green_ofs  <= cfg_data;
        REG_BLUE_OFS:       cfg.blue_ofs   <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage takes new data when empty or when its content moves on
  always_comb begin
    rdy4 = !stage_valid[3] || merge_ready;
    rdy3 = !stage_valid[2] || rdy4;
    rdy2 = !stage_valid[1] || rdy3;
    rdy1 = !stage_valid[0] || rdy2;
    en   = '{p1: rdy1, p2: rdy2, p3: rdy3, p4: rdy4};
  end

  assign s_axis_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (rdy1) stage_valid[0] <= s_axis_tvalid;
      if (rdy2) stage_valid[1] <= stage_valid[0];
      if (rdy3) stage_valid[2] <= stage_valid[1];
      if (rdy4) stage_valid[3] <= stage_valid[2];
    end
  end

  always_comb begin
    luma[0]  = s_axis_tdata[0 +: PIX_W];
    luma[1]  = s_axis_tdata[PIX_W +: PIX_W];
    chroma_u = chroma_u_first ? s_axis_tdata[2 * PIX_W +: PIX_W]
                              : s_axis_tdata[3 * PIX_W +: PIX_W];
    chroma_v = chroma_u_first ? s_axis_tdata[3 * PIX_W +: PIX_W]
                              : s_axis_tdata[2 * PIX_W +: PIX_W];
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    ypr_lane u_lane (
      .clk  (clk),
      .en   (en),
      .cfg  (cfg),
      .luma (luma[l]),
      .u    (chroma_u),
      .v    (chroma_v),
      .res  (lane_res[l])
    );
  end

  ypr_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (stage_valid[3]),
    .lane_res      (lane_res),
    .ready         (merge_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== hw/rtl/ypr_checker.sv =====
// port level checks for yuv_pair_to_rgb, attached by bind
// depends on ypr_pkg and assert_macros.svh
`include "assert_macros.svh"

module ypr_checker import ypr_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  logic xfer_in;
  logic quiet;

  assign xfer_in = s_axis_tvalid && s_axis_tready;
  // no new input and the receiver takes everything
  assign quiet   = !xfer_in && m_axis_tready;

  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")
  `ASSERT_CLK_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "output valid right after reset")
  `ASSERT_CLK(a_ready_flow, m_axis_tready |-> s_axis_tready, "input blocked while output drains")
  `ASSERT_CLK(a_drain, $past(quiet, 1) && $past(quiet, 2) && $past(quiet, 3) && $past(quiet, 4) && $past(quiet, 5) |-> !m_axis_tvalid, "output transfer without input")

endmodule

bind yuv_pair_to_rgb ypr_checker u_ypr_checker (.*);

// ===== sim/tb_yuv_pair_to_rgb.sv =====
`timescale 1ns / 100ps
// testbench for yuv_pair_to_rgb: directed and random pixel pairs under several register
// settings, each result checked field by field against a built-in fixed point predictor
// depends on ypr_pkg and the yuv_pair_to_rgb rtl
module tb_yuv_pair_to_rgb;
  import ypr_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASES         = 6;
  localparam int PAIRS_PER_PHASE = 250;

  // indexes past the last register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam logic [OFS_W-1:0] OFS_MOST_NEG = {1'b1, {(OFS_W-1){1'b0}}};
  localparam logic [OFS_W-1:0] OFS_MOST_POS = {1'b0, {(OFS_W-1){1'b1}}};

  class rgb_scoreboard;
    bit studio;
    bit u_first;
    longint red_ofs;
    longint green_ofs;
    longint blue_ofs;
    logic [OUT_W-1:0] pending_rgb[$];
    int errors;
    string field_names[LANES*CHANS] = '{"red_left", "green_left", "blue_left",
                                        "red_right", "green_right", "blue_right"};

    function new();
      studio    = 1'b0;
      u_first   = 1'b1;
      red_ofs   = -1673527;
      green_ofs = 1263534;
      blue_ofs  = -2114978;
      errors    = 0;
    endfunction

    // fixed point constant rounded to nearest from thousandths
    static function longint coef(int milli);
      return (longint'(milli) * (longint'(1) << FRAC_BITS) + 500) / 1000;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [OFS_W-1:0] data);
      case (idx)
        REG_STUDIO_MODE:    studio = data[0];
        REG_CHROMA_U_FIRST: u_first = data[0];
        REG_RED_OFS:        red_ofs = longint'(signed'(data));
        REG_GREEN_OFS:      green_ofs = longint'(signed'(data));
        REG_BLUE_OFS:       blue_ofs = longint'(signed'(data));
        default: ;
      endcase
    endfunction

    // truncate toward zero, optional studio rescale, clamp
    function logic [PIX_W-1:0] finish_chan(longint sum);
      longint t;
      t = sum / (longint'(1) << FRAC_BITS);
      if (studio) t = ((t - 16) * 255) / 220;
      if (t < 0) return '0;
      if (t > 255) return 8'd255;
      return t[PIX_W-1:0];
    endfunction

    function logic [CHANS*PIX_W-1:0] convert_pixel(longint y, longint u, longint v);
      longint yt, r, g, b;
      if (studio) begin
        yt = y * (longint'(1) << FRAC_BITS);
        r  = yt + coef(1371) * v + red_ofs;
        g  = yt - coef(698) * v - coef(336) * u + green_ofs;
        b  = yt + coef(1732) * u + blue_ofs;
      end else begin
        yt = coef(1164) * ((y > 16) ? y - 16 : longint'(0));
        r  = yt + coef(1596) * v + red_ofs;
        g  = yt - coef(813) * v - coef(392) * u + green_ofs;
        b  = yt + coef(2017) * u + blue_ofs;
      end
      return {finish_chan(b), finish_chan(g), finish_chan(r)};
    endfunction

    function void note_pair(logic [IN_W-1:0] d);
      longint y0, y1, c0, c1, u, v;
      y0 = d[0*PIX_W +: PIX_W];
      y1 = d[1*PIX_W +: PIX_W];
      c0 = d[2*PIX_W +: PIX_W];
      c1 = d[3*PIX_W +: PIX_W];
      u  = u_first ? c0 : c1;
      v  = u_first ? c1 : c0;
      pending_rgb.push_back({convert_pixel(y1, u, v), convert_pixel(y0, u, v)});
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_pixels(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (pending_rgb.size() == 0) begin
        report($sformatf("result %h with no pixel pair outstanding", got));
        return;
      end
      want = pending_rgb.pop_front();
      for (int i = 0; i < LANES*CHANS; i++) begin
        if (got[i*PIX_W +: PIX_W] !== want[i*PIX_W +: PIX_W])
          report($sformatf("%s got %0d expected %0d", field_names[i],
                           got[i*PIX_W +: PIX_W], want[i*PIX_W +: PIX_W]));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [OFS_W-1:0]     cfg_data = '0;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int stall_cycles = 0;
  rgb_scoreboard sb = new();

  yuv_pair_to_rgb i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // receiver backpressure
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(rx_idle_on && $urandom_range(99) < 10);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_pixels(m_axis_tdata);
  end

  // cycles with no transfer on either stream
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [IN_W-1:0] pack_pair(logic [PIX_W-1:0] y0, logic [PIX_W-1:0] y1,
                                                logic [PIX_W-1:0] c0, logic [PIX_W-1:0] c1);
    return {c1, c0, y1, y0};
  endfunction

  // mostly uniform bytes, now and then a level at a range boundary
  function automatic logic [PIX_W-1:0] pick_byte();
    logic [PIX_W-1:0] level_marks[8] = '{8'd0, 8'd15, 8'd16, 8'd17,
                                        8'd128, 8'd235, 8'd240, 8'd255};
    if ($urandom_range(7) == 0) return level_marks[$urandom_range(7)];
    return PIX_W'($urandom_range(255));
  endfunction

  function automatic logic [IN_W-1:0] random_pair();
    return pack_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte());
  endfunction

  // one-bit register word with random upper bits that must be ignored
  function automatic logic [OFS_W-1:0] flag_word(bit b);
    logic [OFS_W-1:0] w;
    w = OFS_W'($urandom);
    w[0] = b;
    return w;
  endfunction

  function automatic logic [OFS_W-1:0] jittered(longint base);
    longint v;
    v = base + longint'($urandom_range(40000)) - 20000;
    return v[OFS_W-1:0];
  endfunction

  // called and returns at a falling edge
  task automatic send_pair(logic [IN_W-1:0] d);
    while (tx_idle_on && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_pair(d);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFS_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // drain the pipeline before touching registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_rgb.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(bit studio, bit u_first, logic [OFS_W-1:0] r_ofs,
                               logic [OFS_W-1:0] g_ofs, logic [OFS_W-1:0] b_ofs);
    settle();
    write_reg(REG_STUDIO_MODE, flag_word(studio));
    write_reg(IDX_SPARE_LO, OFS_W'($urandom));
    write_reg(REG_CHROMA_U_FIRST, flag_word(u_first));
    write_reg(REG_RED_OFS, r_ofs);
    write_reg(REG_GREEN_OFS, g_ofs);
    write_reg(REG_BLUE_OFS, b_ofs);
    write_reg(IDX_SPARE_HI, OFS_W'($urandom));
  endtask

  initial begin
    logic [IN_W-1:0] directed_pairs[$];
    longint full_r, full_g, full_b, studio_r, studio_g, studio_b;

    full_r   = -rgb_scoreboard::coef(1596) * 128;
    full_g   = (rgb_scoreboard::coef(813) + rgb_scoreboard::coef(392)) * 128;
    full_b   = -rgb_scoreboard::coef(2017) * 128;
    studio_r = -rgb_scoreboard::coef(1371) * 128;
    studio_g = (rgb_scoreboard::coef(698) + rgb_scoreboard::coef(336)) * 128;
    studio_b = -rgb_scoreboard::coef(1732) * 128;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // field extremes, luma below black in full range, clamping at both ends
    directed_pairs = {pack_pair(8'd0, 8'd0, 8'd0, 8'd0),
                      pack_pair(8'd255, 8'd255, 8'd255, 8'd255),
                      pack_pair(8'd15, 8'd16, 8'd128, 8'd128),
                      pack_pair(8'd16, 8'd17, 8'd128, 8'd128),
                      pack_pair(8'd0, 8'd255, 8'd0, 8'd255),
                      pack_pair(8'd255, 8'd0, 8'd255, 8'd0),
                      pack_pair(8'd235, 8'd16, 8'd240, 8'd16),
                      pack_pair(8'd128, 8'd128, 8'd0, 8'd255),
                      pack_pair(8'd128, 8'd128, 8'd255, 8'd0),
                      pack_pair(8'd1, 8'd254, 8'd128, 8'd128),
                      pack_pair(8'd235, 8'd235, 8'd128, 8'd128),
                      pack_pair(8'd16, 8'd16, 8'd16, 8'd240),
                      pack_pair(8'd170, 8'd85, 8'd170, 8'd85),
                      pack_pair(8'd85, 8'd170, 8'd85, 8'd170)};
    foreach (directed_pairs[i]) send_pair(directed_pairs[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: apply_setting(1'b1, 1'b1, jittered(studio_r), jittered(studio_g),
                         jittered(studio_b));
        2: apply_setting(1'b0, 1'b0, jittered(full_r), jittered(full_g), jittered(full_b));
        3: apply_setting(1'b1, 1'b0, OFS_MOST_NEG, OFS_MOST_NEG, OFS_MOST_NEG);
        4: apply_setting(1'b0, 1'b1, OFS_MOST_POS, OFS_MOST_POS, OFS_MOST_POS);
        5: apply_setting(1'($urandom_range(1)), 1'($urandom_range(1)), OFS_W'($urandom),
                         OFS_W'($urandom), OFS_W'($urandom));
        default: ;
      endcase
      // phase 2 runs with no idling on either side
      tx_idle_on = (ph != 2);
      rx_idle_on <= (ph != 2);
      for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
        if (ph == 1 && n == PAIRS_PER_PHASE/2) begin
          s_axis_tvalid <= 1'b0;
          @(negedge clk);
          while (sb.pending_rgb.size() != 0) @(negedge clk);
        end
        send_pair(random_pair());
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending_rgb.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
